### hdl/rrtt_pkg.sv
package rrtt_pkg;

    // Table geometry
    localparam int SLOTS     = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int ID_BITS   = 16;

    // Request kinds
    localparam logic [1:0] FN_CREATE = 2'd0;
    localparam logic [1:0] FN_YIELD  = 2'd1;
    localparam logic [1:0] FN_EXIT   = 2'd2;
    localparam logic [1:0] FN_JOIN   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FREE   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_PENDING   = 3'd3;
    localparam logic [2:0] ST_NO_RUN    = 3'd4;

    // Slot states
    localparam logic [1:0] SL_FREE     = 2'd0;
    localparam logic [1:0] SL_RUNNABLE = 2'd1;
    localparam logic [1:0] SL_RUNNING  = 2'd2;
    localparam logic [1:0] SL_ZOMBIE   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] target_id;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] thread_id;
        logic [3:0]  slot;
        logic [3:0]  prev_slot;
    } t_result;

endpackage

### hdl/round_robin_thread_table.sv
// A request accepted while idle is compared against one slot table entry at a time until a
//   match or the end of the scan; the result strobe (o_done) is registered from that step.
// Busy stays high while a single compare unit walks the slot table one entry per cycle; a
//   new request is not taken during a scan, but the next one is taken in the result cycle.
// Reset (synchronous, active low): slot 0 running with id 1, other slots free, id counter 2.
// Results are shown for one cycle only; the receiver cannot stall them.
module round_robin_thread_table
    import rrtt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    localparam logic            FSM_IDLE = 1'b0;
    localparam logic            FSM_SCAN = 1'b1;
    localparam logic [SLOT_BITS:0]   SLOTS_W   = (SLOT_BITS + 1)'(SLOTS);
    localparam logic [SLOT_BITS-1:0] SCAN_LAST = SLOT_BITS'(SLOTS - 1);

    logic                  r_fsm;
    logic [1:0]            r_state [SLOTS];
    logic [ID_BITS-1:0]    r_id    [SLOTS];
    logic [SLOT_BITS-1:0]  r_cur;
    logic [ID_BITS-1:0]    r_ctr;
    logic [1:0]            r_func;
    logic [15:0]           r_target;
    logic [SLOT_BITS-1:0]  r_base;
    logic [SLOT_BITS-1:0]  r_cnt;
    logic                  r_cur_run;
    logic [ID_BITS-1:0]    r_cur_id;
    logic                  r_done;
    t_result               r_res;

    logic                  w_accept;
    logic [SLOT_BITS:0]    w_sum;
    logic [SLOT_BITS-1:0]  w_idx;
    logic [1:0]            w_st;
    logic [ID_BITS-1:0]    w_id;
    logic                  w_hit;
    logic [ID_BITS-1:0]    n_ctr;
    logic [SLOTS-1:0]      w_running;

    assign w_accept = start && !busy;
    assign busy     = (r_fsm == FSM_SCAN);
    assign o_done   = r_done;
    assign o_result = r_res;

    // Scan index: base plus offset, wrapped into the table
    always_comb begin
        w_sum = {1'b0, r_base} + {1'b0, r_cnt};
        if (w_sum >= SLOTS_W) begin
            w_idx = SLOT_BITS'(w_sum - SLOTS_W);
        end else begin
            w_idx = SLOT_BITS'(w_sum);
        end
        w_st = r_state[w_idx];
        w_id = r_id[w_idx];
    end

    // Shared compare unit: match condition per request kind
    always_comb begin
        unique case (r_func) inside
            FN_CREATE:        w_hit = (w_st == SL_FREE);
            FN_YIELD, FN_EXIT: w_hit = (w_st == SL_RUNNABLE);
            FN_JOIN:          w_hit = (w_st != SL_FREE) && (32'(w_id) == 32'(r_target));
            default:          w_hit = 1'b0;
        endcase
    end

    // Next id: advance, wrap, skip zero
    always_comb begin
        n_ctr = r_ctr + ID_BITS'(1);
        if (n_ctr == '0) begin
            n_ctr = ID_BITS'(1);
        end
    end

    // Sequencer and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= FSM_IDLE;
            r_done <= 1'b0;
            r_cur  <= '0;
            r_ctr  <= ID_BITS'(2);
            for (int k = 0; k < SLOTS; k++) begin
                r_state[k] <= (k == 0) ? SL_RUNNING : SL_FREE;
                r_id[k]    <= (k == 0) ? ID_BITS'(1) : '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_fsm)
                FSM_IDLE: begin
                    if (w_accept) begin
                        r_func    <= i_cmd.func;
                        r_target  <= i_cmd.target_id;
                        r_cur_id  <= r_id[r_cur];
                        // Exit leaves no running slot behind to demote
                        r_cur_run <= (r_state[r_cur] == SL_RUNNING) &&
                                     (i_cmd.func != FN_EXIT);
                        r_fsm     <= FSM_SCAN;
                        if (i_cmd.func == FN_CREATE || i_cmd.func == FN_JOIN) begin
                            r_base <= '0;
                            r_cnt  <= '0;
                        end else begin
                            r_base <= r_cur;
                            r_cnt  <= SLOT_BITS'(1);
                        end
                        // Exit: retire the current slot before the switch
                        if (i_cmd.func == FN_EXIT) begin
                            r_state[r_cur] <= SL_ZOMBIE;
                        end
                    end
                end
                FSM_SCAN: begin
                    if (w_hit) begin
                        r_fsm  <= FSM_IDLE;
                        r_done <= 1'b1;
                        unique case (r_func) inside
                            FN_CREATE: begin
                                r_state[w_idx] <= SL_RUNNABLE;
                                r_id[w_idx]    <= r_ctr;
                                r_ctr          <= n_ctr;
                                r_res <= '{status: ST_OK, thread_id: 16'(r_ctr),
                                           slot: 4'(w_idx), prev_slot: 4'd0};
                            end
                            FN_YIELD, FN_EXIT: begin
                                if (r_cur_run) begin
                                    r_state[r_cur] <= SL_RUNNABLE;
                                end
                                r_state[w_idx] <= SL_RUNNING;
                                r_cur          <= w_idx;
                                r_res <= '{status: ST_OK, thread_id: 16'(w_id),
                                           slot: 4'(w_idx), prev_slot: 4'(r_cur)};
                            end
                            default: begin
                                if (w_st == SL_ZOMBIE) begin
                                    r_state[w_idx] <= SL_FREE;
                                    r_id[w_idx]    <= '0;
                                    r_res <= '{status: ST_OK, thread_id: r_target,
                                               slot: 4'(w_idx), prev_slot: 4'd0};
                                end else begin
                                    r_res <= '{status: ST_PENDING, thread_id: r_target,
                                               slot: 4'(w_idx), prev_slot: 4'd0};
                                end
                            end
                        endcase
                    end else if (r_cnt == SCAN_LAST) begin
                        // Table exhausted: report the miss
                        r_fsm  <= FSM_IDLE;
                        r_done <= 1'b1;
                        unique case (r_func) inside
                            FN_CREATE: begin
                                r_res <= '{status: ST_NO_FREE, thread_id: 16'd0,
                                           slot: 4'd0, prev_slot: 4'd0};
                            end
                            FN_YIELD, FN_EXIT: begin
                                r_res <= '{status: ST_NO_RUN, thread_id: 16'(r_cur_id),
                                           slot: 4'(r_cur), prev_slot: 4'(r_cur)};
                            end
                            default: begin
                                r_res <= '{status: ST_NOT_FOUND, thread_id: r_target,
                                           slot: 4'd0, prev_slot: 4'd0};
                            end
                        endcase
                    end else begin
                        r_cnt <= r_cnt + SLOT_BITS'(1);
                    end
                end
                default: r_fsm <= FSM_IDLE;
            endcase
        end
    end

    // Running-slot map for checks
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            w_running[k] = (r_state[k] == SL_RUNNING);
        end
    end

    // At most one slot is ever running
    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_running))
        else $error("more than one running slot");

    // A result beat only ends a scan
    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result beat without a scan");

    // An accepted request always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted request did not start a scan");

    // Status stays within defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.status <= ST_NO_RUN)
        else $error("undefined status code");

    // Id counter never holds zero
    a_ctr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctr != '0)
        else $error("id counter reached zero");

endmodule

### verif/round_robin_thread_table_tb.sv
module round_robin_thread_table_tb;
    import rrtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS  = 1550;
    localparam int WATCHDOG = 1000;
    localparam int DRAIN    = SLOTS + 4;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Scheduler image kept alongside the block
    logic [1:0]           tbl_state [SLOTS];
    logic [ID_BITS-1:0]   tbl_id    [SLOTS];
    logic [SLOT_BITS-1:0] cur_slot;
    logic [ID_BITS-1:0]   next_id;

    t_cmd    cmd_q[$];
    t_result sched_q[$];
    t_result want;
    int      n_queued   = 0;
    int      n_accepted = 0;
    int      n_err      = 0;
    int      quiet_cycles = 0;
    int      idle_pct;

    round_robin_thread_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Work out the scheduler outcome of one request and update the image
    function automatic t_result sched_predict(t_cmd c);
        t_result              r;
        int                   hit;
        logic [SLOT_BITS-1:0] idx;
        logic [SLOT_BITS-1:0] prev;
        r   = '0;
        hit = -1;
        case (c.func)
            FN_CREATE: begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && tbl_state[i] == SL_FREE) hit = i;
                if (hit < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    tbl_id[hit]    = next_id;
                    tbl_state[hit] = SL_RUNNABLE;
                    next_id        = next_id + 1'b1;
                    if (next_id == '0) next_id = ID_BITS'(1);
                    r.status    = ST_OK;
                    r.thread_id = tbl_id[hit];
                    r.slot      = hit[SLOT_BITS-1:0];
                end
            end
            FN_JOIN: begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && tbl_state[i] != SL_FREE && tbl_id[i] == c.target_id)
                        hit = i;
                r.thread_id = c.target_id;
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (tbl_state[hit] == SL_ZOMBIE) begin
                    // reap the zombie, even when it is the current slot
                    tbl_state[hit] = SL_FREE;
                    tbl_id[hit]    = '0;
                    r.status       = ST_OK;
                    r.slot         = hit[SLOT_BITS-1:0];
                end else begin
                    r.status = ST_PENDING;
                    r.slot   = hit[SLOT_BITS-1:0];
                end
            end
            default: begin
                // yield, or exit followed by yield
                prev = cur_slot;
                if (c.func == FN_EXIT) tbl_state[cur_slot] = SL_ZOMBIE;
                for (int i = 1; i < SLOTS; i++) begin
                    idx = cur_slot + i[SLOT_BITS-1:0];
                    if (hit < 0 && tbl_state[idx] == SL_RUNNABLE) hit = idx;
                end
                if (hit < 0) begin
                    r.status = ST_NO_RUN;
                end else begin
                    if (tbl_state[cur_slot] == SL_RUNNING) tbl_state[cur_slot] = SL_RUNNABLE;
                    tbl_state[hit] = SL_RUNNING;
                    cur_slot       = hit[SLOT_BITS-1:0];
                    r.status       = ST_OK;
                end
                r.thread_id = tbl_id[cur_slot];
                r.slot      = cur_slot;
                r.prev_slot = prev;
            end
        endcase
        return r;
    endfunction

    function automatic void push_cmd(logic [1:0] f, logic [15:0] id);
        t_cmd c;
        c.func      = f;
        c.target_id = id;
        cmd_q.push_back(c);
        n_queued++;
    endfunction

    task automatic flag_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
        n_err++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, got_v);
    endtask

    // Driver: record each accepted beat, then offer the next request or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                tbl_state[i] = SL_FREE;
                tbl_id[i]    = '0;
            end
            tbl_state[0] = SL_RUNNING;
            tbl_id[0]    = ID_BITS'(1);
            cur_slot     = '0;
            next_id      = ID_BITS'(2);
        end else begin
            if (start && !busy) begin
                sched_q.push_back(sched_predict(i_cmd));
                n_accepted++;
            end
            if (!start || !busy) begin
                if (n_accepted < N_ITEMS / 3)          idle_pct = 38;
                else if (n_accepted < 2 * N_ITEMS / 3) idle_pct = 50;
                else                                   idle_pct = 0;
                if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_cmd <= cmd_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: match each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sched_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result, expected none actual %p", $time, o_result);
            end else begin
                want = sched_q.pop_front();
                if (o_result.status !== want.status)
                    flag_mismatch("status", 16'(want.status), 16'(o_result.status));
                if (o_result.thread_id !== want.thread_id)
                    flag_mismatch("thread_id", want.thread_id, o_result.thread_id);
                if (o_result.slot !== want.slot)
                    flag_mismatch("slot", 16'(want.slot), 16'(o_result.slot));
                if (o_result.prev_slot !== want.prev_slot)
                    flag_mismatch("prev_slot", 16'(want.prev_slot),
                                  16'(o_result.prev_slot));
            end
        end
    end

    // Watchdog: stop when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] zombie_ids[$];
        logic [15:0] live_ids[$];
        int          roll;
        logic [1:0]  f;
        logic [15:0] id;

        // Lone thread: yield and exit with nothing else runnable, join edge ids
        push_cmd(FN_YIELD, 16'h0000);
        push_cmd(FN_JOIN, 16'h0001);
        push_cmd(FN_JOIN, 16'h0000);
        push_cmd(FN_JOIN, 16'hFFFF);
        push_cmd(FN_EXIT, 16'h0000);
        // reap the current zombie, then yield from a freed current slot
        push_cmd(FN_JOIN, 16'h0001);
        push_cmd(FN_YIELD, 16'h0000);
        // current slot refilled as runnable: yield finds no other, then leaves it
        push_cmd(FN_CREATE, 16'hFFFF);
        push_cmd(FN_YIELD, 16'h0000);
        push_cmd(FN_CREATE, 16'h0000);
        push_cmd(FN_YIELD, 16'hAAAA);
        // fill the table, then one create too many
        for (int i = 0; i < SLOTS - 1; i++) push_cmd(FN_CREATE, 16'h5555);

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random part: requests built from the current table so joins mostly hit
        while (n_queued < N_ITEMS) begin
            while (cmd_q.size() >= 2) @(posedge i_clk);
            zombie_ids.delete();
            live_ids.delete();
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_state[i] == SL_ZOMBIE) zombie_ids.push_back(tbl_id[i]);
                if (tbl_state[i] != SL_FREE)   live_ids.push_back(tbl_id[i]);
            end
            roll = $urandom_range(99);
            id   = 16'($urandom);
            if (roll < 30)      f = FN_CREATE;
            else if (roll < 55) f = FN_YIELD;
            else if (roll < 75) f = FN_EXIT;
            else                f = FN_JOIN;
            if (f == FN_JOIN) begin
                roll = $urandom_range(99);
                if (roll < 60 && zombie_ids.size() != 0)
                    id = zombie_ids[$urandom_range(zombie_ids.size() - 1)];
                else if (roll < 80 && live_ids.size() != 0)
                    id = live_ids[$urandom_range(live_ids.size() - 1)];
                else if (roll < 85)
                    id = '0;
            end
            push_cmd(f, id);
        end

        // Drain: all beats accepted, all results back, then a few spare cycles
        while (n_accepted < n_queued) @(posedge i_clk);
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
